// ----- rtl/core/polyphonic_dds_tone_mixer_assert.svh -----
// ---------------------------------------------------------------------------
// polyphonic dds tone mixer assertion macros
// concurrent check shorthands shared by the rtl that asserts
// ---------------------------------------------------------------------------
`ifndef POLYPHONIC_DDS_TONE_MIXER_ASSERT_SVH
`define POLYPHONIC_DDS_TONE_MIXER_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define PTM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, ignored while in reset
`define PTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- rtl/core/ptm_pkg.sv -----
// ---------------------------------------------------------------------------
// ptm_pkg
// shared types, constants and the sine table of the tone mixer
// ---------------------------------------------------------------------------
package ptm_pkg;

    localparam int VOICES_DEF     = 4;
    localparam int PHASE_W        = 16;
    localparam int SHIFT_W        = 3;
    localparam int CNT_W          = 20;
    localparam int RATE_MHZ       = 10121457;
    localparam int SAMPLES_PER_MS = 10;
    localparam int MAX_VOLUME     = 7;

    // phase step as a reciprocal multiply: estimate is low by at most one
    localparam int STEP_NUM   = 65535;
    localparam int STEP_SHIFT = 24;
    localparam int STEP_Q_W   = 17;
    localparam logic [STEP_Q_W-1:0] STEP_RECIP =
        STEP_Q_W'((longint'(STEP_NUM) << STEP_SHIFT) / longint'(RATE_MHZ));

    // serial divider geometry for the mix average
    localparam int DIV_D_W    = 24;
    localparam int DIV_Q_W    = 17;
    localparam int DIV_S_W    = 5;
    localparam int MIX_STEPS  = 8;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_PLAY = 2'd1,
        KIND_STOP = 2'd2
    } kind_t;

    // one voice entry as stored in the voice memory
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [PHASE_W-1:0] step;
        logic [SHIFT_W-1:0] shift;
        logic [CNT_W-1:0]   count;
        logic [CNT_W-1:0]   limit;
    } voice_t;

    typedef struct packed {
        logic               start;
        logic [DIV_S_W-1:0] steps;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    localparam logic [7:0] QUARTER_WAVE [64] = '{
        8'h80, 8'h83, 8'h86, 8'h89, 8'h8c, 8'h8f, 8'h92, 8'h95,
        8'h98, 8'h9c, 8'h9f, 8'ha2, 8'ha5, 8'ha8, 8'hab, 8'hae,
        8'hb0, 8'hb3, 8'hb6, 8'hb9, 8'hbc, 8'hbf, 8'hc1, 8'hc4,
        8'hc7, 8'hc9, 8'hcc, 8'hce, 8'hd1, 8'hd3, 8'hd5, 8'hd8,
        8'hda, 8'hdc, 8'hde, 8'he0, 8'he2, 8'he4, 8'he6, 8'he8,
        8'hea, 8'heb, 8'hed, 8'hef, 8'hf0, 8'hf2, 8'hf3, 8'hf4,
        8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa, 8'hfb, 8'hfb, 8'hfc,
        8'hfd, 8'hfd, 8'hfe, 8'hfe, 8'hfe, 8'hff, 8'hff, 8'hff
    };

    // full sine from the quarter table, mirrored and inverted by quadrant
    function automatic logic [7:0] wave_at(input logic [7:0] x);
        logic [7:0] w;
        case (x[7:6])
            2'd0:    w = QUARTER_WAVE[x[5:0]];
            2'd1:    w = QUARTER_WAVE[~x[5:0]];
            2'd2:    w = ~QUARTER_WAVE[x[5:0]];
            default: w = ~QUARTER_WAVE[~x[5:0]];
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/ptm_ram.sv -----
// ---------------------------------------------------------------------------
// ptm_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module ptm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/ptm_div.sv -----
// ---------------------------------------------------------------------------
// ptm_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module ptm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptm_pkg::div_cmd_t             cmd,
    input  logic [ptm_pkg::DIV_D_W-1:0]   rem_init,
    input  logic [ptm_pkg::DIV_Q_W-1:0]   low_init,
    input  logic [ptm_pkg::DIV_D_W-1:0]   divisor,
    output ptm_pkg::div_stat_t            stat,
    output logic [ptm_pkg::DIV_Q_W-1:0]   quot
);
    import ptm_pkg::*;

    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_Q_W-1:0] low_reg, low_next;
    logic [DIV_Q_W-1:0] quot_reg, quot_next;
    logic [DIV_D_W-1:0] dvs_reg, dvs_next;
    logic [DIV_S_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_D_W:0]   trial;
    logic               fits;

    // remainder stays below the divisor, so one extra bit holds the trial
    assign trial = {rem_reg, low_reg[DIV_Q_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            rem_next  = rem_init;
            low_next  = low_init;
            quot_next = '0;
            dvs_next  = divisor;
            cnt_next  = cmd.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? DIV_D_W'(trial - {1'b0, dvs_reg}) : trial[DIV_D_W-1:0];
            low_next  = {low_reg[DIV_Q_W-2:0], 1'b0};
            quot_next = {quot_reg[DIV_Q_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_S_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

// ----- rtl/core/ptm_voice.sv -----
// ---------------------------------------------------------------------------
// ptm_voice
// one voice update: table lookup, volume shift, phase and count advance
// ---------------------------------------------------------------------------
module ptm_voice (
    input  ptm_pkg::voice_t cur,
    output ptm_pkg::voice_t nxt,
    output logic [7:0]      smp,
    output logic            expired
);
    import ptm_pkg::*;

    logic [7:0] raw;

    assign raw = wave_at(cur.phase[PHASE_W-1:PHASE_W-8]);
    assign smp = raw >> cur.shift;

    always_comb
    begin
        nxt       = cur;
        nxt.phase = PHASE_W'(cur.phase + cur.step);
        nxt.count = CNT_W'(cur.count + 1'b1);
    end

    assign expired = (nxt.count == cur.limit);

endmodule

// ----- rtl/core/polyphonic_dds_tone_mixer.sv -----
// ---------------------------------------------------------------------------
// polyphonic_dds_tone_mixer
// multi-voice dds sine tone generator with averaging mixer
// ---------------------------------------------------------------------------
// One beat in gives one beat out; a new beat is taken only once the previous
// result has been registered and the sequencer is back in idle. A tick beat
// with playback on walks the voice memory one entry per cycle (read, update,
// write back) and then averages the live voices through the serial divider:
// a setup state that starts it, eight quotient steps and a wait state that
// sees the divider finish. If no voice was live the divide is skipped. A play
// beat that finds a free voice takes the phase step from a reciprocal
// multiply, a back multiply and a one-step correction, in the states estimate,
// multiply and write. Stop, dropped play, idle tick and unused beats go
// straight to the result state. The memory needs no clearing pass: an entry is
// only used once a play has written it in full. The finished result sits in an
// output register so a new beat is taken while the previous result still waits
// downstream; only a second result waiting stalls the sequencer.
// ---------------------------------------------------------------------------
`include "polyphonic_dds_tone_mixer_assert.svh"

module polyphonic_dds_tone_mixer #(
    parameter int VOICES = ptm_pkg::VOICES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [23:0] frequency_mhz,
    input  logic [15:0] duration_ms,
    input  logic [2:0]  volume,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  sample,
    output logic        sample_valid,
    output logic        busy_res,
    output logic        dropped
);
    import ptm_pkg::*;

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VCNT_W = $clog2(VOICES + 1);
    localparam int NUM_W  = $clog2(VOICES + 1);
    localparam int SUM_W  = 9 + $clog2(VOICES);
    localparam int VW     = $bits(voice_t);
    localparam int PROD_W = 24 + STEP_Q_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MIX,
        S_MIX_DIV,
        S_PLAY_EST,
        S_PLAY_MUL,
        S_PLAY_WR,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [VOICES-1:0]   live_reg, live_next;
    logic                play_reg, play_next;
    logic [VCNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                pend_reg, pend_next;
    logic [VIDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [VIDX_W-1:0]   slot_reg, slot_next;
    logic [15:0]         dur_reg, dur_next;
    logic [2:0]          vol_reg, vol_next;
    logic [23:0]         freq_reg, freq_next;
    logic [STEP_Q_W-1:0] est_reg, est_next;
    logic [PROD_W-1:0]   back_reg, back_next;
    // result being built
    logic [7:0]          r_smp_reg, r_smp_next;
    logic                r_sv_reg, r_sv_next;
    logic                r_drop_reg, r_drop_next;
    // output register
    logic                ov_reg, ov_next;
    logic [7:0]          o_smp_reg, o_smp_next;
    logic                o_sv_reg, o_sv_next;
    logic                o_busy_reg, o_busy_next;
    logic                o_drop_reg, o_drop_next;

    // voice memory ports
    logic                ram_we;
    logic [VIDX_W-1:0]   ram_waddr;
    voice_t              ram_wdata;
    logic [VIDX_W-1:0]   ram_raddr;
    logic [VW-1:0]       ram_rdata;

    voice_t              cur_voice, upd_voice, new_voice;
    logic [7:0]          voice_smp;
    logic                voice_expired;

    // divider hookup
    div_cmd_t            div_cmd;
    div_stat_t           div_stat;
    logic [DIV_D_W-1:0]  div_rem;
    logic [DIV_Q_W-1:0]  div_low;
    logic [DIV_D_W-1:0]  div_dvs;
    logic [DIV_Q_W-1:0]  div_quot;

    // phase step datapath
    logic [39:0]         step_prod;
    logic [PROD_W-1:0]   est_prod;
    logic [PROD_W-1:0]   back_prod;
    logic [PROD_W-1:0]   step_rem;
    logic                step_fix;

    // free voice search, lowest index wins
    logic                free_found;
    logic [VIDX_W-1:0]   free_idx;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = VOICES - 1; v >= 0; v--)
        begin
            if (!live_reg[v])
            begin
                free_found = 1'b1;
                free_idx   = VIDX_W'(v);
            end
        end
    end

    // frequency times 0xffff as shift and subtract
    assign step_prod = {freq_reg, 16'h0000} - {16'h0000, freq_reg};

    // estimate of the step, at most one below the true quotient
    assign est_prod  = {{STEP_Q_W{1'b0}}, freq_reg} * {24'd0, STEP_RECIP};
    // estimate times the rate constant, subtracted to get the remainder
    assign back_prod = {24'd0, est_reg} * PROD_W'(RATE_MHZ);
    assign step_rem  = PROD_W'(step_prod) - back_reg;
    assign step_fix  = (step_rem >= PROD_W'(RATE_MHZ));

    assign cur_voice = ram_rdata;

    ptm_ram #(
        .WIDTH (VW),
        .DEPTH (VOICES),
        .AW    (VIDX_W)
    ) u_voice_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ptm_voice u_voice (
        .cur     (cur_voice),
        .nxt     (upd_voice),
        .smp     (voice_smp),
        .expired (voice_expired)
    );

    ptm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .rem_init (div_rem),
        .low_init (div_low),
        .divisor  (div_dvs),
        .stat     (div_stat),
        .quot     (div_quot)
    );

    // entry written by a play beat once its step is known
    always_comb
    begin
        new_voice       = '0;
        new_voice.step  = est_reg[PHASE_W-1:0] + PHASE_W'(step_fix);
        new_voice.shift = SHIFT_W'(MAX_VOLUME) - vol_reg;
        new_voice.limit = CNT_W'(dur_reg * SAMPLES_PER_MS);
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        live_next     = live_reg;
        play_next     = play_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        sum_next      = sum_reg;
        num_next      = num_reg;
        slot_next     = slot_reg;
        dur_next      = dur_reg;
        vol_next      = vol_reg;
        freq_next     = freq_reg;
        est_next      = est_reg;
        back_next     = back_reg;
        r_smp_next    = r_smp_reg;
        r_sv_next     = r_sv_reg;
        r_drop_next   = r_drop_reg;
        ov_next       = ov_reg;
        o_smp_next    = o_smp_reg;
        o_sv_next     = o_sv_reg;
        o_busy_next   = o_busy_reg;
        o_drop_next   = o_drop_reg;

        ram_we    = 1'b0;
        ram_waddr = pend_idx_reg;
        ram_wdata = upd_voice;
        ram_raddr = rd_idx_reg[VIDX_W-1:0];

        div_cmd = '0;
        div_rem = '0;
        div_low = '0;
        div_dvs = '0;

        // output register drains independently of the sequencer
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    r_smp_next  = '0;
                    r_sv_next   = 1'b0;
                    r_drop_next = 1'b0;
                    state_next  = S_DONE;
                    case (kind)
                        KIND_TICK:
                        begin
                            if (play_reg)
                            begin
                                rd_idx_next = '0;
                                sum_next    = '0;
                                num_next    = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        KIND_PLAY:
                        begin
                            play_next = 1'b1;
                            if (free_found)
                            begin
                                slot_next  = free_idx;
                                dur_next   = duration_ms;
                                vol_next   = volume;
                                freq_next  = frequency_mhz;
                                state_next = S_PLAY_EST;
                            end
                            else
                            begin
                                r_drop_next = 1'b1;
                            end
                        end
                        KIND_STOP:
                        begin
                            live_next = '0;
                        end
                        default:
                        begin
                            // unused code, result carries only the busy flag
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue a read per cycle, update the entry read in the previous cycle;
                // write and read addresses never coincide during the walk
                if (rd_idx_reg < VCNT_W'(VOICES))
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[VIDX_W-1:0];
                    rd_idx_next   = VCNT_W'(rd_idx_reg + 1'b1);
                end
                if (pend_reg)
                begin
                    if (live_reg[pend_idx_reg])
                    begin
                        ram_we   = 1'b1;
                        sum_next = SUM_W'(sum_reg + SUM_W'(voice_smp));
                        num_next = NUM_W'(num_reg + 1'b1);
                        if (voice_expired)
                        begin
                            live_next[pend_idx_reg] = 1'b0;
                        end
                    end
                    if (pend_idx_reg == VIDX_W'(VOICES - 1))
                    begin
                        state_next = S_MIX;
                    end
                end
            end

            S_MIX:
            begin
                r_sv_next = 1'b1;
                if (num_reg == '0)
                begin
                    // nothing live: silence and leave playback
                    r_smp_next = '0;
                    play_next  = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    // average is below 256, so eight steps suffice
                    div_cmd.start = 1'b1;
                    div_cmd.steps = DIV_S_W'(MIX_STEPS);
                    div_rem       = DIV_D_W'(sum_reg >> MIX_STEPS);
                    div_low       = {sum_reg[MIX_STEPS-1:0], (DIV_Q_W - MIX_STEPS)'(0)};
                    div_dvs       = DIV_D_W'(num_reg);
                    state_next    = S_MIX_DIV;
                end
            end

            S_MIX_DIV:
            begin
                if (div_stat.done)
                begin
                    r_smp_next = div_quot[7:0];
                    state_next = S_DONE;
                end
            end

            S_PLAY_EST:
            begin
                est_next   = est_prod[STEP_SHIFT +: STEP_Q_W];
                state_next = S_PLAY_MUL;
            end

            S_PLAY_MUL:
            begin
                back_next  = back_prod;
                state_next = S_PLAY_WR;
            end

            S_PLAY_WR:
            begin
                // remainder still holds one divisor: the estimate was one low
                ram_we              = 1'b1;
                ram_waddr           = slot_reg;
                ram_wdata           = new_voice;
                live_next[slot_reg] = 1'b1;
                state_next          = S_DONE;
            end

            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next     = 1'b1;
                    o_smp_next  = r_smp_reg;
                    o_sv_next   = r_sv_reg;
                    o_busy_next = (|live_reg) | play_reg;
                    o_drop_next = r_drop_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            live_reg   <= '0;
            play_reg   <= 1'b0;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            live_reg   <= live_next;
            play_reg   <= play_next;
            rd_idx_reg <= rd_idx_next;
            pend_reg   <= pend_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        sum_reg      <= sum_next;
        num_reg      <= num_next;
        slot_reg     <= slot_next;
        dur_reg      <= dur_next;
        vol_reg      <= vol_next;
        freq_reg     <= freq_next;
        est_reg      <= est_next;
        back_reg     <= back_next;
        r_smp_reg    <= r_smp_next;
        r_sv_reg     <= r_sv_next;
        r_drop_reg   <= r_drop_next;
        o_smp_reg    <= o_smp_next;
        o_sv_reg     <= o_sv_next;
        o_busy_reg   <= o_busy_next;
        o_drop_reg   <= o_drop_next;
    end

    assign out_valid    = ov_reg;
    assign sample       = o_smp_reg;
    assign sample_valid = o_sv_reg;
    assign busy_res     = o_busy_reg;
    assign dropped      = o_drop_reg;

    // an accepted beat always takes the sequencer out of idle
    `PTM_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, !in_ready)
    // a nonzero mix means a voice was live, so playback is still on
    `PTM_ASSERT_IMPL(a_sound_implies_busy, clk, rst_n, ov_reg && (o_smp_reg != '0), o_busy_reg)
    // a drop only comes from a play beat, never with a tick sample
    `PTM_ASSERT_IMPL(a_drop_not_tick, clk, rst_n, ov_reg && o_drop_reg, !o_sv_reg)
    // memory walk never writes the entry it is reading
    `PTM_ASSERT_IMPL(a_scan_no_overlap, clk, rst_n,
        ram_we && (state_reg == S_SCAN) && pend_next, ram_waddr != ram_raddr)
    // divider results arrive only while a divide is awaited
    `PTM_ASSERT_IMPL(a_div_done_expected, clk, rst_n, div_stat.done, state_reg == S_MIX_DIV)

endmodule
